>>> src/bac_pkg.sv
// bac_pkg: shared types, constants and aes round functions
// depends on nothing
`default_nettype none
package bac_pkg;

    localparam int MAX_LEN = 255;
    localparam logic [7:0] B0_FLAGS = 8'h49;
    localparam logic [7:0] CTR_FLAGS = 8'h01;
    localparam int BLK = 16;
    localparam int QDEPTH = 2;

    // configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [39:0] nonce_high;
        logic [63:0] nonce_low;
        logic [7:0]  aad_byte;
        logic [7:0]  payload_len;
        logic [7:0]  data_byte;
        logic [31:0] received_mic;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] mic_out;
        logic        auth_ok;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_B0, S_B1, S_S0, S_BYTE, S_CTR, S_XOR, S_MAC, S_OUT
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] next_rk(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic fin);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) & 3))];
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8*i -: 8] = t[i];
        end
        return o ^ rk;
    endfunction

endpackage
`default_nettype wire

>>> src/bac_aes.sv
// bac_aes: iterative aes-128 encryptor, one round per cycle, keys expanded on the fly
// depends on bac_pkg
`default_nettype none
module bac_aes
    import bac_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_block,
    input  wire logic [127:0] i_key,
    output logic              o_busy,
    output logic              o_done,
    output logic [127:0]      o_result
);
    logic [127:0] r_s, r_rk;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic         r_busy, r_done;
    logic [127:0] n_rk;

    assign n_rk = next_rk(r_rk, r_rc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_rnd == 4'd10) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s   <= i_block ^ i_key;
            r_rk  <= i_key;
            r_rc  <= 8'h01;
            r_rnd <= 4'd1;
        end else if (r_busy) begin
            r_s   <= aes_round(r_s, n_rk, r_rnd == 4'd10);
            r_rk  <= n_rk;
            r_rc  <= xtime(r_rc);
            r_rnd <= r_rnd + 4'd1;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_s;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("aes started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done longer than one cycle");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while still busy");
endmodule
`default_nettype wire

>>> src/bac_front.sv
// bac_front: input side, takes items into a two-entry queue
// depends on bac_pkg
`default_nettype none
module bac_front
    import bac_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_q_valid,
    output t_in_item      o_q_item,
    input  wire logic     i_q_pop
);
    t_in_item   r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall = (r_cnt == 2'(QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_in_item;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue overfilled");
    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'(QDEPTH)) |-> r_wp == r_rp) else $error("pointer slip");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> src/bac_back.sv
// bac_back: packet sequencer, ccm mac and ctr over a shared aes core
// depends on bac_pkg, bac_aes
`default_nettype none
module bac_back
    import bac_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [127:0] i_key,
    input  wire logic         i_q_valid,
    input  wire t_in_item     i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output t_out_item         o_out_item
);
    t_state       r_state, n_state;
    t_in_item     r_item;
    logic [127:0] r_mac, r_ks, r_plain;
    logic [31:0]  r_mask;
    logic [7:0]   r_cnt;
    logic         r_inpkt;
    logic [103:0] r_nonce;
    logic [7:0]   r_ob;
    logic         r_bv, r_last;
    logic         r_ovalid;
    t_out_item    r_out;

    logic         aes_start, aes_busy, aes_done;
    logic [127:0] aes_in, aes_res;
    logic [3:0]   pos;
    logic [127:0] plain_base, plain_new;
    logic [7:0]   ob, pb;
    logic         last_now;
    logic         out_free;
    logic [31:0]  tag;

    bac_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aes_start),
        .i_block  (aes_in),
        .i_key    (i_key),
        .o_busy   (aes_busy),
        .o_done   (aes_done),
        .o_result (aes_res)
    );

    assign pos        = r_cnt[3:0];
    assign plain_base = (pos == 4'd0) ? 128'd0 : r_plain;
    assign ob         = r_item.data_byte ^ r_ks[127 - 8*pos -: 8];
    assign pb         = r_item.cmd ? ob : r_item.data_byte;
    assign last_now   = (9'(r_cnt) + 9'd1) >= 9'(r_item.payload_len);
    always_comb begin
        plain_new = plain_base;
        plain_new[127 - 8*pos -: 8] = pb;
    end
    assign out_free = !r_ovalid || !i_out_stall;
    assign tag      = r_mac[127:96] ^ r_mask;

    always_comb begin
        n_state   = r_state;
        aes_start = 1'b0;
        aes_in    = 128'd0;
        o_q_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!r_inpkt) begin
                        aes_start = 1'b1;
                        aes_in    = {B0_FLAGS, i_q_item.nonce_high, i_q_item.nonce_low,
                                     8'h00, i_q_item.payload_len};
                        n_state   = S_B0;
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_B0: begin
                if (aes_done) begin
                    aes_start = 1'b1;
                    aes_in    = aes_res ^ {8'h00, 8'h01, r_item.aad_byte, 104'd0};
                    n_state   = S_B1;
                end
            end
            S_B1: begin
                if (aes_done) begin
                    aes_start = 1'b1;
                    aes_in    = {CTR_FLAGS, r_nonce, 16'd0};
                    n_state   = S_S0;
                end
            end
            S_S0: begin
                if (aes_done) begin
                    n_state = (r_item.payload_len == 8'd0) ? S_OUT : S_BYTE;
                end
            end
            S_BYTE: begin
                if (pos == 4'd0) begin
                    aes_start = 1'b1;
                    aes_in    = {CTR_FLAGS, r_nonce, 16'(r_cnt[7:4]) + 16'd1};
                    n_state   = S_CTR;
                end else begin
                    n_state = S_XOR;
                end
            end
            S_CTR: begin
                if (aes_done) n_state = S_XOR;
            end
            S_XOR: begin
                if (pos == 4'd15 || last_now) begin
                    aes_start = 1'b1;
                    aes_in    = r_mac ^ plain_new;
                    n_state   = S_MAC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MAC: begin
                if (aes_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inpkt  <= 1'b0;
            r_cnt    <= 8'd0;
            r_ovalid <= 1'b0;
            r_mac    <= 128'd0;
            r_ks     <= 128'd0;
            r_plain  <= 128'd0;
            r_mask   <= 32'd0;
            r_nonce  <= 104'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall)            r_ovalid <= 1'b0;
            unique case (r_state) inside
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_bv   <= 1'b0;
                        r_ob   <= 8'd0;
                        r_last <= 1'b1;
                        if (!r_inpkt) r_nonce <= {i_q_item.nonce_high, i_q_item.nonce_low};
                    end
                end
                S_B0, S_B1: if (aes_done) r_mac <= aes_res;
                S_S0: begin
                    if (aes_done) begin
                        r_mask  <= aes_res[127:96];
                        r_ks    <= 128'd0;
                        r_plain <= 128'd0;
                        r_cnt   <= 8'd0;
                        r_inpkt <= 1'b1;
                    end
                end
                S_CTR: if (aes_done) r_ks <= aes_res;
                S_XOR: begin
                    r_plain <= plain_new;
                    r_ob    <= ob;
                    r_bv    <= 1'b1;
                    r_last  <= last_now;
                end
                S_MAC: if (aes_done) r_mac <= aes_res;
                S_OUT: begin
                    if (out_free) begin
                        r_out.out_byte    <= r_ob;
                        r_out.byte_valid  <= r_bv;
                        r_out.last        <= r_last;
                        r_out.mic_out     <= r_last ? tag : 32'd0;
                        r_out.auth_ok     <= r_last && r_item.cmd &&
                                             (tag == r_item.received_mic);
                        if (r_last) r_inpkt <= 1'b0;
                        if (r_bv) r_cnt <= r_cnt + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        aes_start |-> !aes_busy) else $error("aes launched while busy");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_ovalid) else $error("result lost");
endmodule
`default_nettype wire

>>> src/ble_aes_ccm_packet_crypt.sv
// ble_aes_ccm_packet_crypt: aes-128-ccm link-layer packet engine, top level
// depends on bac_pkg, bac_front, bac_back
//
// channel  direction  handshake                 beat
// input    in         i_in_valid / o_in_stall   t_in_item, one payload byte
// output   out        o_out_valid / i_out_stall t_out_item, one result
// config   in         i_cfg_valid / o_cfg_ready key half by index
//
// each byte passes through the idle, byte, xor and out states, plus a ctr block at each
// 16-byte boundary and the mac block at each 16th or final byte; the first item of a
// packet also runs b0, b1 and s0 on the single round-per-cycle aes core.
// synchronous active-low reset clears key, chain and packet state.
// a two-beat queue and an output register let either side stall on its own.
`default_nettype none
module ble_aes_ccm_packet_crypt
    import bac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_key_hi, r_key_lo;
    logic        q_valid, q_pop;
    t_in_item    q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= 64'd0;
            r_key_lo <= 64'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KEY_LOW) r_key_lo <= i_cfg_data;
            else                            r_key_hi <= i_cfg_data;
        end
    end

    bac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    bac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       ({r_key_hi, r_key_lo}),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench for the ble_aes_ccm_packet_crypt packet engine
// holds an aes-128-ccm byte tracker class and random packet stimulus with stalls
// depends on bac_pkg and the block's rtl
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bac_pkg::*;

    class ccm_tracker;
        logic [127:0] round_key [11];
        logic [127:0] mac_chain, keystream, plain_blk;
        logic [31:0]  tag_mask;
        logic [103:0] nonce;
        int           byte_cnt;
        bit           in_pkt;
        t_out_item    pending [$];
        int           errors;

        function new();
            set_key(128'h0);
        endfunction

        function void set_key(logic [127:0] key);
            logic [31:0] w [44];
            logic [31:0] t;
            logic [7:0]  rc;
            rc = 8'h01;
            for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
            for (int i = 4; i < 44; i++) begin
                t = w[i-1];
                if (i % 4 == 0) begin
                    t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]],
                         SBOX[t[31:24]]};
                    rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
                end
                w[i] = w[i-4] ^ t;
            end
            for (int r = 0; r < 11; r++)
                round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        endfunction

        function logic [7:0] dbl(logic [7:0] a);
            return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [127:0] cipher(logic [127:0] blk);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, al;
            for (int i = 0; i < 16; i++)
                s[i] = blk[127 - 8*i -: 8] ^ round_key[0][127 - 8*i -: 8];
            for (int r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) t[i + 4*c] = SBOX[s[i + 4*((c + i) & 3)]];
                if (r != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                        t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                        t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                        t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[r][127 - 8*i -: 8];
            end
            for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
            return blk;
        endfunction

        // tag of an empty packet, state untouched
        function logic [31:0] empty_tag(logic [103:0] n, logic [7:0] aad);
            logic [127:0] m, s0;
            m  = cipher({B0_FLAGS, n, 16'h0000});
            m  = cipher(m ^ {8'h00, 8'h01, aad, 104'h0});
            s0 = cipher({CTR_FLAGS, n, 16'h0000});
            return m[127:96] ^ s0[127:96];
        endfunction

        function t_out_item note_input(t_in_item it);
            t_out_item r;
            logic [127:0] s0;
            logic [7:0]   ob;
            int           pos;
            bit           fin;
            r = '0;
            fin = 1'b0;
            if (!in_pkt) begin
                nonce     = {it.nonce_high, it.nonce_low};
                mac_chain = cipher({B0_FLAGS, nonce, 8'h00, it.payload_len});
                mac_chain = cipher(mac_chain ^ {8'h00, 8'h01, it.aad_byte, 104'h0});
                s0        = cipher({CTR_FLAGS, nonce, 16'h0000});
                tag_mask  = s0[127:96];
                keystream = '0;
                plain_blk = '0;
                byte_cnt  = 0;
                in_pkt    = 1'b1;
                if (it.payload_len == 0) fin = 1'b1;
            end
            if (!fin) begin
                pos = byte_cnt % 16;
                if (pos == 0) begin
                    keystream = cipher({CTR_FLAGS, nonce, 16'(byte_cnt / 16 + 1)});
                    plain_blk = '0;
                end
                ob = it.data_byte ^ keystream[127 - 8*pos -: 8];
                plain_blk[127 - 8*pos -: 8] = it.cmd ? ob : it.data_byte;
                fin = (byte_cnt + 1 >= it.payload_len);
                if (pos == 15 || fin) mac_chain = cipher(mac_chain ^ plain_blk);
                byte_cnt++;
                r.out_byte   = ob;
                r.byte_valid = 1'b1;
            end
            if (fin) begin
                in_pkt    = 1'b0;
                r.last    = 1'b1;
                r.mic_out = mac_chain[127:96] ^ tag_mask;
                r.auth_ok = it.cmd && (r.mic_out == it.received_mic);
            end
            pending.push_back(r);
            return r;
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_byte !== e.out_byte) begin
                $error("out_byte exp %h got %h", e.out_byte, got.out_byte); errors++;
            end
            if (got.byte_valid !== e.byte_valid) begin
                $error("byte_valid exp %b got %b", e.byte_valid, got.byte_valid); errors++;
            end
            if (got.last !== e.last) begin
                $error("last exp %b got %b", e.last, got.last); errors++;
            end
            if (got.mic_out !== e.mic_out) begin
                $error("mic_out exp %h got %h", e.mic_out, got.mic_out); errors++;
            end
            if (got.auth_ok !== e.auth_ok) begin
                $error("auth_ok exp %b got %b", e.auth_ok, got.auth_ok); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    ble_aes_ccm_packet_crypt i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE = 80;

    ccm_tracker   sb = new();
    logic [127:0] cur_key;
    bit           in_quiet, out_quiet;
    int           out_wait, out_beats, idle_cycles;
    // last encrypted packet, replayed for decryption
    logic [103:0] rp_nonce;
    logic [7:0]   rp_aad, rp_len;
    logic [7:0]   rp_cipher [$];
    logic [31:0]  rp_tag;
    bit           rp_ok;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each beat, random stall per beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_item);
                out_beats++;
                if (out_beats % 60 == 0) out_quiet = !out_quiet;
                out_wait = out_quiet ? 0 : $urandom_range(0, 11);
            end else if (out_wait > 0) begin
                out_wait--;
            end
        end
        i_out_stall <= (out_wait > 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(t_in_item it);
        int gap;
        t_out_item r;
        gap = in_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = sb.note_input(it);
        if (it.cmd == 1'b0 && r.byte_valid) rp_cipher.push_back(r.out_byte);
        if (it.cmd == 1'b0 && r.last) rp_tag = r.mic_out;
    endtask

    task automatic write_key(logic [127:0] key);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        for (int idx = 0; idx < 2; idx++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (idx == 0) ? CFG_KEY_HIGH : CFG_KEY_LOW;
            i_cfg_data  <= idx == 0 ? key[127:64] : key[63:0];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        sb.set_key(key);
        cur_key = key;
    endtask

    // one packet; replay decrypts the last encrypted packet, broken varies length, nonce, cmd and mic
    task automatic run_packet(bit dec, int len, bit replay, bit broken, bit good_mic);
        t_in_item it;
        int n;
        it.cmd          = dec;
        it.nonce_high   = 40'({$urandom(), $urandom()});
        it.nonce_low    = {$urandom(), $urandom()};
        it.aad_byte     = 8'($urandom());
        it.payload_len  = 8'(len);
        it.received_mic = $urandom();
        if (replay) begin
            {it.nonce_high, it.nonce_low} = rp_nonce;
            it.aad_byte     = rp_aad;
            it.payload_len  = rp_len;
            it.received_mic = good_mic ? rp_tag : rp_tag ^ (32'h1 << $urandom_range(0, 31));
        end else if (!dec) begin
            rp_nonce = {it.nonce_high, it.nonce_low};
            rp_aad   = it.aad_byte;
            rp_len   = 8'(len);
            rp_cipher.delete();
            rp_ok    = !broken;
        end
        if (dec && good_mic && len == 0 && !replay)
            it.received_mic = sb.empty_tag({it.nonce_high, it.nonce_low}, it.aad_byte);
        n = it.payload_len == 0 ? 1 : it.payload_len;
        for (int k = 0; k < n; k++) begin
            it.data_byte = (replay && k < rp_cipher.size()) ? rp_cipher[k] : 8'($urandom());
            if (broken && $urandom_range(0, 7) == 0) begin
                it.payload_len = 8'($urandom());
                it.nonce_low   = {$urandom(), $urandom()};
                it.cmd         = 1'($urandom());
                it.received_mic = $urandom();
            end
            send_beat(it);
        end
    endtask

    task automatic random_phase(int items);
        int done, len, pick;
        done = 0;
        while (done < items) begin
            in_quiet = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 60) == 0) ? 255 : $urandom_range(0, 40);
            if (pick < 35) begin
                run_packet(1'b0, len, 1'b0, 1'b0, 1'b0);
            end else if (pick < 60 && rp_ok) begin
                run_packet(1'b1, rp_len, 1'b1, 1'b0, $urandom_range(0, 3) != 0);
                len = rp_len;
                rp_ok = 1'b0;
            end else if (pick < 85) begin
                run_packet(1'b1, len, 1'b0, 1'b0, len == 0 && $urandom_range(0, 1));
            end else begin
                run_packet(1'($urandom()), len, 1'b0, 1'b1, 1'b0);
            end
            done += (len == 0) ? 1 : len;
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KEY_HIGH;
        i_cfg_data  = '0;
        out_wait    = 0;
        out_beats   = 0;
        idle_cycles = 0;
        out_quiet   = 1'b0;
        in_quiet    = 1'b0;
        rp_ok       = 1'b0;
        cur_key     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset key, empty packets, block boundaries, replay with good tag
        run_packet(1'b0, 0, 1'b0, 1'b0, 1'b0);
        run_packet(1'b1, 0, 1'b0, 1'b0, 1'b1);
        run_packet(1'b1, 0, 1'b0, 1'b0, 1'b0);
        run_packet(1'b0, 1, 1'b0, 1'b0, 1'b0);
        run_packet(1'b1, 1, 1'b1, 1'b0, 1'b1);
        write_key({128{1'b1}});
        run_packet(1'b0, 17, 1'b0, 1'b0, 1'b0);
        run_packet(1'b1, 17, 1'b1, 1'b0, 1'b1);

        write_key({$urandom(), $urandom(), $urandom(), $urandom()});
        run_packet(1'b0, 255, 1'b0, 1'b0, 1'b0);
        run_packet(1'b1, 255, 1'b1, 1'b0, 1'b0);
        random_phase(80);
        write_key('0);
        random_phase(50);
        write_key({$urandom(), $urandom(), $urandom(), $urandom()});
        random_phase(70);
        write_key({128{1'b1}});
        random_phase(50);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/bac_pkg.sv
src/bac_aes.sv
src/bac_front.sv
src/bac_back.sv
src/ble_aes_ccm_packet_crypt.sv
dv/tb_top.sv
